// ===== hw/rtl/rper_pkg.sv =====
package rper_pkg;

    localparam int MAX_PAIRS      = 64;
    localparam int DATA_WIDTH     = 16;
    localparam int TRIG_WIDTH     = 16;
    localparam int TRIG_FRAC_BITS = 14;

    // counter and register widths
    localparam int PAIR_W  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int PPH_W   = 7;
    localparam int HEAD_W  = 8;
    localparam int HC_W    = 9;
    localparam int POS_W   = 16;
    localparam int BATCH_W = 16;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // datapath widths: product, exact sum of two products, rounded, accumulated
    localparam int PROD_W = DATA_WIDTH + TRIG_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RND_W  = SUM_W - TRIG_FRAC_BITS;
    localparam int ACC_W  = RND_W + 1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DIRECTION      = 3'd0,
        REG_PAIRS_PER_HEAD = 3'd1,
        REG_ROTARY_PAIRS   = 3'd2,
        REG_HEAD_COUNT     = 3'd3,
        REG_POSITION_COUNT = 3'd4,
        REG_BATCH_COUNT    = 3'd5
    } t_cfg_addr;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic signed [TRIG_WIDTH-1:0] t_trig;

    // effective configuration, zero counts and overlarge sizes already folded
    typedef struct packed {
        logic               backward;
        logic [PPH_W-1:0]   pph;
        logic [PPH_W-1:0]   rot;
        logic [HC_W-1:0]    hc;
        logic [POS_W-1:0]   pc;
        logic [BATCH_W-1:0] bc;
    } t_cfg;

    // per-word control from the sequencer
    typedef struct packed {
        logic rotate;
        logic backward;
        logic end_of_head;
        logic end_of_tensor;
    } t_ctrl;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    function automatic logic is_clipped(input logic signed [ACC_W-1:0] v);
        return (v > SAT_HI) || (v < SAT_LO);
    endfunction

    function automatic t_data saturate(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        r = v;
        if (v > SAT_HI) begin
            r = SAT_HI;
        end else if (v < SAT_LO) begin
            r = SAT_LO;
        end
        return t_data'(r[DATA_WIDTH-1:0]);
    endfunction

endpackage

// ===== hw/rtl/rper_in_if.sv =====
interface rper_in_if import rper_pkg::*; ();
    logic  valid;
    logic  ready;
    t_data first_value;
    t_data second_value;
    t_trig cos_value;
    t_trig sin_value;
    t_data prior_first;
    t_data prior_second;

    modport source (output valid, first_value, second_value, cos_value, sin_value,
                    prior_first, prior_second, input ready);
    modport sink   (input valid, first_value, second_value, cos_value, sin_value,
                    prior_first, prior_second, output ready);
endinterface

// ===== hw/rtl/rper_out_if.sv =====
interface rper_out_if import rper_pkg::*; ();
    logic  valid;
    logic  ready;
    t_data out_first;
    t_data out_second;
    logic  saturated;
    logic  end_of_head;
    logic  end_of_tensor;

    modport source (output valid, out_first, out_second, saturated, end_of_head,
                    end_of_tensor, input ready);
    modport sink   (input valid, out_first, out_second, saturated, end_of_head,
                    end_of_tensor, output ready);
endinterface

// ===== hw/rtl/rper_cfg_if.sv =====
interface rper_cfg_if import rper_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// ===== hw/rtl/rotary_embedding_pair_rotator.sv =====
// Interleaved rotary position embedding, one element pair per word.
// Input channel i_in: a pair (first_value, second_value), its cos/sin in
// Q1.14 and, in backward mode, the prior gradient pair. Output channel o_out:
// the saturated pair, a clip flag and end-of-head / end-of-tensor marks.
// Config channel i_cfg: always ready; addr selects direction, pairs_per_head,
// rotated pair count, head_count, position_count, batch_count (0..5). Write
// only while the pipe is empty; unknown addresses are dropped.
// Pipeline: input register, product register holding four 16x16 multiplies,
// result register; o_out.valid is driven from the result register.
// Throughput: one word per cycle; the three stages advance independently so
// a word is taken while a finished result waits, up to three words in flight.
// Stall: when o_out.ready is low, the result holds and the stages behind it
// fill; i_in.ready drops only once all three stages are full.
// Reset (i_rst_n low, synchronous): pipe emptied, pair/head/position/batch
// counters zeroed, registers back to forward, 64 pairs, 64 rotary, 1/1/1.
module rotary_embedding_pair_rotator import rper_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rper_in_if.sink     i_in,
    rper_out_if.source  o_out,
    rper_cfg_if.sink    i_cfg
);

    t_cfg  cfg;      // effective register values
    t_ctrl ctrl;     // rotate/direction/end marks for the word at the input
    logic  accept;   // input word taken this cycle

    rper_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // walks pair -> head -> position -> batch, one step per accepted word
    rper_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .o_ctrl   (ctrl)
    );

    // three-stage arithmetic pipe with per-stage valid and stall
    rper_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_ctrl   (ctrl),
        .o_accept (accept)
    );

`ifndef SYNTH
    // tensor end always coincides with a head end
    a_eot_implies_eoh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.end_of_tensor) |-> o_out.end_of_head)
        else $error("end_of_tensor without end_of_head");

    // an empty result stage never backpressures the input
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled with empty output stage");

    // reset empties the pipe
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");
`endif

endmodule

// ===== hw/rtl/rper_cfg_regs.sv =====
module rper_cfg_regs import rper_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rper_cfg_if.sink      i_cfg,
    output t_cfg          o_cfg
);

    logic               r_direction;
    logic [PPH_W-1:0]   r_pph;
    logic [PPH_W-1:0]   r_rot;
    logic [HC_W-1:0]    r_hc;
    logic [POS_W-1:0]   r_pc;
    logic [BATCH_W-1:0] r_bc;

    logic [PPH_W-1:0]   pph_nz;
    logic [PPH_W-1:0]   pph_eff;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
            r_pph       <= PPH_W'(MAX_PAIRS);
            r_rot       <= PPH_W'(MAX_PAIRS);
            r_hc        <= HC_W'(1);
            r_pc        <= POS_W'(1);
            r_bc        <= BATCH_W'(1);
        end else if (i_cfg.valid) begin
            case (t_cfg_addr'(i_cfg.addr))
                REG_DIRECTION:      r_direction <= i_cfg.data[0];
                REG_PAIRS_PER_HEAD: r_pph       <= i_cfg.data[PPH_W-1:0];
                REG_ROTARY_PAIRS:   r_rot       <= i_cfg.data[PPH_W-1:0];
                REG_HEAD_COUNT:     r_hc        <= i_cfg.data[HC_W-1:0];
                REG_POSITION_COUNT: r_pc        <= i_cfg.data[POS_W-1:0];
                REG_BATCH_COUNT:    r_bc        <= i_cfg.data[BATCH_W-1:0];
                default: ;
            endcase
        end
    end

    // zero pair/head/position/batch counts act as one, head size clamps to the pair capacity
    assign pph_nz  = (r_pph == '0) ? PPH_W'(1) : r_pph;
    assign pph_eff = (pph_nz > PPH_W'(MAX_PAIRS)) ? PPH_W'(MAX_PAIRS) : pph_nz;

    always_comb begin
        o_cfg.backward = r_direction;
        o_cfg.pph      = pph_eff;
        o_cfg.rot      = (r_rot > pph_eff) ? pph_eff : r_rot;
        o_cfg.hc       = (r_hc == '0) ? HC_W'(1) : r_hc;
        o_cfg.pc       = (r_pc == '0) ? POS_W'(1) : r_pc;
        o_cfg.bc       = (r_bc == '0) ? BATCH_W'(1) : r_bc;
    end

endmodule

// ===== hw/rtl/rper_seq.sv =====
module rper_seq import rper_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_accept,
    output t_ctrl o_ctrl
);

    logic [PAIR_W-1:0]  r_pair;
    logic [HEAD_W-1:0]  r_head;
    logic [POS_W-1:0]   r_pos;
    logic [BATCH_W-1:0] r_batch;

    logic [PAIR_W-1:0]  n_pair;
    logic [HEAD_W-1:0]  n_head;
    logic [POS_W-1:0]   n_pos;
    logic [BATCH_W-1:0] n_batch;

    logic [PPH_W-1:0]   pair_inc;
    logic [HC_W-1:0]    head_inc;
    logic [POS_W:0]     pos_inc;
    logic [BATCH_W:0]   batch_inc;
    logic               last_pair;
    logic               last_head;
    logic               last_pos;
    logic               last_batch;

    // a counter past its count counts as last
    assign pair_inc   = PPH_W'(r_pair) + PPH_W'(1);
    assign head_inc   = HC_W'(r_head) + HC_W'(1);
    assign pos_inc    = {1'b0, r_pos} + (POS_W+1)'(1);
    assign batch_inc  = {1'b0, r_batch} + (BATCH_W+1)'(1);
    assign last_pair  = pair_inc >= i_cfg.pph;
    assign last_head  = head_inc >= i_cfg.hc;
    assign last_pos   = pos_inc >= {1'b0, i_cfg.pc};
    assign last_batch = batch_inc >= {1'b0, i_cfg.bc};

    always_comb begin
        o_ctrl.rotate        = PPH_W'(r_pair) < i_cfg.rot;
        o_ctrl.backward      = i_cfg.backward;
        o_ctrl.end_of_head   = last_pair;
        o_ctrl.end_of_tensor = last_pair && last_head && last_pos && last_batch;
    end

    always_comb begin
        n_pair  = r_pair;
        n_head  = r_head;
        n_pos   = r_pos;
        n_batch = r_batch;
        if (!last_pair) begin
            n_pair = pair_inc[PAIR_W-1:0];
        end else begin
            n_pair = '0;
            if (!last_head) begin
                n_head = head_inc[HEAD_W-1:0];
            end else begin
                n_head = '0;
                if (!last_pos) begin
                    n_pos = pos_inc[POS_W-1:0];
                end else begin
                    n_pos = '0;
                    n_batch = last_batch ? '0 : batch_inc[BATCH_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair  <= '0;
            r_head  <= '0;
            r_pos   <= '0;
            r_batch <= '0;
        end else if (i_accept) begin
            r_pair  <= n_pair;
            r_head  <= n_head;
            r_pos   <= n_pos;
            r_batch <= n_batch;
        end
    end

endmodule

// ===== hw/rtl/rper_dp.sv =====
module rper_dp import rper_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rper_in_if.sink      i_in,
    rper_out_if.source   o_out,
    input  t_ctrl        i_ctrl,
    output logic         o_accept
);

    // stage enables: a stage loads when empty or when it drains downstream
    logic en1;
    logic en2;
    logic en3;

    // stage 1: input register
    logic  r_v1;
    t_ctrl r_ctrl1;
    t_data r_a1;
    t_data r_b1;
    t_trig r_c1;
    t_trig r_s1;
    t_data r_pa1;
    t_data r_pb1;

    // stage 2: products
    logic                     r_v2;
    t_ctrl                    r_ctrl2;
    t_data                    r_a2;
    t_data                    r_b2;
    t_data                    r_pa2;
    t_data                    r_pb2;
    logic signed [PROD_W-1:0] r_ac;
    logic signed [PROD_W-1:0] r_bs;
    logic signed [PROD_W-1:0] r_as;
    logic signed [PROD_W-1:0] r_bc;

    // stage 3: result register
    logic  r_v3;
    t_data r_out_first;
    t_data r_out_second;
    logic  r_sat;
    logic  r_eoh;
    logic  r_eot;

    logic signed [SUM_W-1:0] ac_x;
    logic signed [SUM_W-1:0] bs_x;
    logic signed [SUM_W-1:0] as_x;
    logic signed [SUM_W-1:0] bc_x;
    logic signed [SUM_W-1:0] sum1;
    logic signed [SUM_W-1:0] sum2;
    logic signed [RND_W-1:0] base1;
    logic signed [RND_W-1:0] base2;
    logic signed [ACC_W-1:0] acc1;
    logic signed [ACC_W-1:0] acc2;
    logic signed [ACC_W-1:0] prior1;
    logic signed [ACC_W-1:0] prior2;

    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (TRIG_FRAC_BITS - 1);

    assign en3        = !r_v3 || o_out.ready;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign i_in.ready = en1;
    assign o_accept   = i_in.valid && en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_accept) begin
            r_ctrl1 <= i_ctrl;
            r_a1    <= i_in.first_value;
            r_b1    <= i_in.second_value;
            r_c1    <= i_in.cos_value;
            r_s1    <= i_in.sin_value;
            r_pa1   <= i_in.prior_first;
            r_pb1   <= i_in.prior_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_ctrl2 <= r_ctrl1;
            r_a2    <= r_a1;
            r_b2    <= r_b1;
            r_pa2   <= r_pa1;
            r_pb2   <= r_pb1;
            r_ac    <= r_a1 * r_c1;
            r_bs    <= r_b1 * r_s1;
            r_as    <= r_a1 * r_s1;
            r_bc    <= r_b1 * r_c1;
        end
    end

    // exact sums, then round half up by flooring after adding half an LSB
    assign ac_x = {{(SUM_W-PROD_W){r_ac[PROD_W-1]}}, r_ac};
    assign bs_x = {{(SUM_W-PROD_W){r_bs[PROD_W-1]}}, r_bs};
    assign as_x = {{(SUM_W-PROD_W){r_as[PROD_W-1]}}, r_as};
    assign bc_x = {{(SUM_W-PROD_W){r_bc[PROD_W-1]}}, r_bc};

    always_comb begin
        if (r_ctrl2.backward) begin
            sum1 = ac_x + bs_x + HALF;
            sum2 = bc_x - as_x + HALF;
        end else begin
            sum1 = ac_x - bs_x + HALF;
            sum2 = as_x + bc_x + HALF;
        end
        if (r_ctrl2.rotate) begin
            base1 = sum1[SUM_W-1:TRIG_FRAC_BITS];
            base2 = sum2[SUM_W-1:TRIG_FRAC_BITS];
        end else begin
            base1 = {{(RND_W-DATA_WIDTH){r_a2[DATA_WIDTH-1]}}, r_a2};
            base2 = {{(RND_W-DATA_WIDTH){r_b2[DATA_WIDTH-1]}}, r_b2};
        end
        if (r_ctrl2.backward) begin
            prior1 = {{(ACC_W-DATA_WIDTH){r_pa2[DATA_WIDTH-1]}}, r_pa2};
            prior2 = {{(ACC_W-DATA_WIDTH){r_pb2[DATA_WIDTH-1]}}, r_pb2};
        end else begin
            prior1 = '0;
            prior2 = '0;
        end
        acc1 = {base1[RND_W-1], base1} + prior1;
        acc2 = {base2[RND_W-1], base2} + prior2;
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            r_out_first  <= saturate(acc1);
            r_out_second <= saturate(acc2);
            r_sat        <= is_clipped(acc1) || is_clipped(acc2);
            r_eoh        <= r_ctrl2.end_of_head;
            r_eot        <= r_ctrl2.end_of_tensor;
        end
    end

    assign o_out.valid         = r_v3;
    assign o_out.out_first     = r_out_first;
    assign o_out.out_second    = r_out_second;
    assign o_out.saturated     = r_sat;
    assign o_out.end_of_head   = r_eoh;
    assign o_out.end_of_tensor = r_eot;

endmodule
